// ===== design/ihm_pkg.sv =====
package ihm_pkg;

  localparam int MAX_PAIRS_DEF   = 1024;
  localparam int MAX_BUCKETS_DEF = 2048;
  localparam int KEY_W           = 31;
  localparam int VAL_W           = 32;
  localparam int CNT_W           = 11;
  localparam int BC_CFG_W        = 12;
  localparam int ME_CFG_W        = 11;
  localparam int CFG_DATA_W      = 12;

  typedef enum logic [0:0] {
    CFG_BUCKET_COUNT = 1'b0,
    CFG_MAX_ENTRIES  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_DUP     = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_HWAIT,
    S_WALK,
    S_NCHK,
    S_DECIDE,
    S_FWAIT,
    S_REM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;
  } out_t;

endpackage

// ===== design/ihm_mod.sv =====
module ihm_mod #(
  parameter int KW = 31,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [KW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(KW + 1);

  logic [DW-1:0] rem;
  logic [KW-1:0] kq;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial     = {rem, kq[KW-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(KW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      kq  <= dividend;
    end else if (busy) begin
      kq <= kq << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= DW'(trial - {1'b0, divisor});
      end else begin
        rem <= DW'(trial);
      end
    end
  end

endmodule

// ===== design/integer_hash_map_core.sv =====
// Integer key to value map with separately chained buckets.
// An input transaction carries an opcode, a key and a value; every input
// transaction yields exactly one output transaction with found, value,
// status and the pair count after the operation.
// The configuration port writes the bucket count (which empties the table)
// and the entry limit; the user must see that it is used only while the
// block is idle, as the block itself does not enforce this.
// An operation reduces the key modulo the bucket count, one quotient bit per
// cycle, then fetches the bucket head, then visits the chain node by node,
// each node being a synchronous read of the node memory, until it finds the
// key or reaches the end of the chain, and then decides, writes back and
// loads the output register. Clear and the unused opcodes skip the search.
// Operations are handled one at a time.
// After reset, after a clear operation and after a bucket count write, the
// bucket memory is swept, one bucket per cycle, and no input transaction is
// accepted during the sweep.
// The result sits in an output register; a stalled receiver holds it there,
// the next input transaction is still accepted, and its result waits until
// the register is free.
module integer_hash_map_core #(
  parameter int MAX_PAIRS   = ihm_pkg::MAX_PAIRS_DEF,
  parameter int MAX_BUCKETS = ihm_pkg::MAX_BUCKETS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ihm_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ihm_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [ihm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW  = $clog2(MAX_PAIRS + 1);
  localparam int NW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DW  = $clog2(MAX_BUCKETS + 1);
  localparam logic [AW-1:0] NIL = AW'(MAX_PAIRS);

  typedef struct packed {
    logic [ihm_pkg::KEY_W-1:0] key;
    logic [ihm_pkg::VAL_W-1:0] value;
    logic [AW-1:0]             link;
  } node_t;

  ihm_pkg::state_t state, state_next;

  node_t                        nd_mem [MAX_PAIRS];
  logic [AW-1:0]                bh_mem [MAX_BUCKETS];

  logic [2:0]                   op;
  logic [ihm_pkg::KEY_W-1:0]    key;
  logic [ihm_pkg::VAL_W-1:0]    val;
  logic [BW-1:0]                bkt;
  logic [AW-1:0]                head, cur, prev, free_head, hwm, pair_count;
  node_t                        cur_rec, prev_rec, nd_rd;
  logic [AW-1:0]                bh_rd;
  logic [BW-1:0]                sweep_idx;
  logic                         clr_pend;
  logic [ihm_pkg::BC_CFG_W-1:0] bc_cfg;
  logic [ihm_pkg::ME_CFG_W-1:0] me_cfg;
  logic                         found;
  logic [ihm_pkg::VAL_W-1:0]    vout;
  ihm_pkg::status_t             status;

  logic                         in_acc, out_free, full, mod_start, mod_done;
  logic [DW-1:0]                mod_rem, divisor;
  logic [31:0]                  bc32, lim32;
  logic                         bh_we, nd_we;
  logic [BW-1:0]                bh_waddr;
  logic [AW-1:0]                bh_wdata, nd_waddr, nd_raddr;
  node_t                        nd_wdata;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    bc32 = 32'(bc_cfg);
    if (bc_cfg == '0) begin
      bc32 = 32'd1;
    end else if (32'(bc_cfg) > 32'(MAX_BUCKETS)) begin
      bc32 = 32'(MAX_BUCKETS);
    end
    lim32 = (32'(me_cfg) > 32'(MAX_PAIRS)) ? 32'(MAX_PAIRS) : 32'(me_cfg);
  end

  assign divisor = DW'(bc32);
  assign full    = 32'(pair_count) >= lim32;

  ihm_mod #(.KW(ihm_pkg::KEY_W), .DW(DW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_data.key),
    .divisor  (divisor),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ihm_pkg::S_SWEEP: begin
        if (sweep_idx == BW'(MAX_BUCKETS - 1)) state_next = ihm_pkg::S_IDLE;
      end
      ihm_pkg::S_IDLE: begin
        if (cfg_we && cfg_index == ihm_pkg::CFG_BUCKET_COUNT) begin
          state_next = ihm_pkg::S_SWEEP;
        end else if (in_acc) begin
          if (in_data.opcode <= 3'(ihm_pkg::OP_LOOKUP)) state_next = ihm_pkg::S_MOD;
          else state_next = ihm_pkg::S_DONE;
        end
      end
      ihm_pkg::S_MOD:   if (mod_done) state_next = ihm_pkg::S_HEAD;
      ihm_pkg::S_HEAD:  state_next = ihm_pkg::S_HWAIT;
      ihm_pkg::S_HWAIT: state_next = ihm_pkg::S_WALK;
      ihm_pkg::S_WALK: begin
        state_next = (cur == NIL) ? ihm_pkg::S_DECIDE : ihm_pkg::S_NCHK;
      end
      ihm_pkg::S_NCHK: begin
        state_next = (nd_rd.key == key) ? ihm_pkg::S_DECIDE : ihm_pkg::S_WALK;
      end
      ihm_pkg::S_DECIDE: begin
        state_next = ihm_pkg::S_DONE;
        if (op == 3'(ihm_pkg::OP_INSERT) && !found && !full && free_head != NIL) begin
          state_next = ihm_pkg::S_FWAIT;
        end else if (op == 3'(ihm_pkg::OP_REMOVE) && found) begin
          state_next = ihm_pkg::S_REM;
        end
      end
      ihm_pkg::S_FWAIT: state_next = ihm_pkg::S_DONE;
      ihm_pkg::S_REM:   state_next = ihm_pkg::S_DONE;
      ihm_pkg::S_DONE: begin
        if (out_free) state_next = clr_pend ? ihm_pkg::S_SWEEP : ihm_pkg::S_IDLE;
      end
      default: state_next = ihm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ihm_pkg::S_IDLE) || cfg_we;
    mod_start = 1'b0;
    bh_we     = 1'b0;
    bh_waddr  = bkt;
    bh_wdata  = NIL;
    nd_we     = 1'b0;
    nd_waddr  = cur;
    nd_wdata  = cur_rec;
    nd_raddr  = cur;
    unique case (state)
      ihm_pkg::S_SWEEP: begin
        bh_we    = 1'b1;
        bh_waddr = sweep_idx;
      end
      ihm_pkg::S_IDLE: begin
        mod_start = in_acc && in_data.opcode <= 3'(ihm_pkg::OP_LOOKUP);
      end
      ihm_pkg::S_DECIDE: begin
        nd_raddr = free_head;
        if (op == 3'(ihm_pkg::OP_INSERT) && !found && !full && free_head == NIL) begin
          nd_we    = 1'b1;
          nd_waddr = hwm;
          nd_wdata = '{key: key, value: val, link: head};
          bh_we    = 1'b1;
          bh_wdata = hwm;
        end else if (op == 3'(ihm_pkg::OP_UPDATE) && found) begin
          nd_we          = 1'b1;
          nd_wdata.value = val;
        end else if (op == 3'(ihm_pkg::OP_REMOVE) && found) begin
          if (prev == NIL) begin
            bh_we    = 1'b1;
            bh_wdata = cur_rec.link;
          end else begin
            nd_we         = 1'b1;
            nd_waddr      = prev;
            nd_wdata      = prev_rec;
            nd_wdata.link = cur_rec.link;
          end
        end
      end
      ihm_pkg::S_FWAIT: begin
        nd_we    = 1'b1;
        nd_waddr = free_head;
        nd_wdata = '{key: key, value: val, link: head};
        bh_we    = 1'b1;
        bh_wdata = free_head;
      end
      ihm_pkg::S_REM: begin
        nd_we         = 1'b1;
        nd_wdata.link = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bh_we) bh_mem[bh_waddr] <= bh_wdata;
    bh_rd <= bh_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (nd_we) nd_mem[nd_waddr[NW-1:0]] <= nd_wdata;
    nd_rd <= nd_mem[nd_raddr[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ihm_pkg::S_SWEEP;
      sweep_idx  <= '0;
      clr_pend   <= 1'b0;
      bc_cfg     <= ihm_pkg::BC_CFG_W'(1);
      me_cfg     <= '0;
      free_head  <= NIL;
      hwm        <= '0;
      pair_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != ihm_pkg::S_DONE) out_valid <= 1'b0;
      if (cfg_we && cfg_index == ihm_pkg::CFG_MAX_ENTRIES) begin
        me_cfg <= cfg_data[ihm_pkg::ME_CFG_W-1:0];
      end
      if (cfg_we && cfg_index == ihm_pkg::CFG_BUCKET_COUNT) begin
        bc_cfg     <= cfg_data;
        sweep_idx  <= '0;
        free_head  <= NIL;
        hwm        <= '0;
        pair_count <= '0;
      end
      case (state)
        ihm_pkg::S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          clr_pend  <= 1'b0;
        end
        ihm_pkg::S_IDLE: begin
          if (in_acc && in_data.opcode == 3'(ihm_pkg::OP_CLEAR)) begin
            clr_pend   <= 1'b1;
            sweep_idx  <= '0;
            free_head  <= NIL;
            hwm        <= '0;
            pair_count <= '0;
          end
        end
        ihm_pkg::S_DECIDE: begin
          if (op == 3'(ihm_pkg::OP_INSERT) && !found && !full && free_head == NIL) begin
            hwm        <= hwm + 1'b1;
            pair_count <= pair_count + 1'b1;
          end
        end
        ihm_pkg::S_FWAIT: begin
          free_head  <= nd_rd.link;
          pair_count <= pair_count + 1'b1;
        end
        ihm_pkg::S_REM: begin
          free_head <= cur;
          if (pair_count != '0) pair_count <= pair_count - 1'b1;
        end
        ihm_pkg::S_DONE: begin
          if (out_free) out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ihm_pkg::S_IDLE: begin
        op     <= in_data.opcode;
        key    <= in_data.key;
        val    <= in_data.value_in;
        found  <= 1'b0;
        vout   <= '0;
        status <= ihm_pkg::ST_OK;
      end
      ihm_pkg::S_MOD:   if (mod_done) bkt <= mod_rem[BW-1:0];
      ihm_pkg::S_HWAIT: begin
        head <= bh_rd;
        cur  <= bh_rd;
        prev <= NIL;
      end
      ihm_pkg::S_NCHK: begin
        if (nd_rd.key == key) begin
          found   <= 1'b1;
          cur_rec <= nd_rd;
        end else begin
          prev     <= cur;
          prev_rec <= nd_rd;
          cur      <= nd_rd.link;
        end
      end
      ihm_pkg::S_DECIDE: begin
        if (op == 3'(ihm_pkg::OP_INSERT)) begin
          if (found) status <= ihm_pkg::ST_DUP;
          else if (full) status <= ihm_pkg::ST_FULL;
        end else if (!found) begin
          status <= ihm_pkg::ST_MISSING;
        end else if (op == 3'(ihm_pkg::OP_LOOKUP)) begin
          vout <= cur_rec.value;
        end
      end
      ihm_pkg::S_DONE: begin
        if (out_free) begin
          out_data.found       <= found;
          out_data.value_out   <= vout;
          out_data.status      <= status;
          out_data.entry_count <= ihm_pkg::CNT_W'(pair_count);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    32'(pair_count) <= 32'(MAX_PAIRS))
    else $error("pair count above pool size");

  a_hwm_bound : assert property (@(posedge clk) disable iff (rst)
    32'(hwm) <= 32'(MAX_PAIRS) && pair_count <= hwm)
    else $error("allocation mark inconsistent with pair count");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != ihm_pkg::S_IDLE)
    else $error("accepted transaction did not start");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int HW_PAIRS = ihm_pkg::MAX_PAIRS_DEF;
  localparam int SETTLE = 2300;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RESET_ROWS = 8;

  typedef struct {
    logic [2:0] op;
    logic [ihm_pkg::KEY_W-1:0] key;
    logic [ihm_pkg::VAL_W-1:0] val;
    bit typed;
    ihm_pkg::out_t res;
  } row_t;

  typedef struct {
    bit write_bc;
    int bc;
    int me;
    int items;
    int span;
    bit calm;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ihm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ihm_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = ihm_pkg::CFG_BUCKET_COUNT;
  logic [ihm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [ihm_pkg::VAL_W-1:0] map_pairs [logic [ihm_pkg::KEY_W-1:0]];
  logic [ihm_pkg::KEY_W-1:0] key_list[$];
  int entry_limit;
  ihm_pkg::out_t pending[$];
  int failures = 0;
  int results_seen = 0;
  int hits = 0;
  int cycles = 0;
  bit calm = 1'b0;
  row_t rows[$];
  phase_t phases[$];

  integer_hash_map_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = !rst && !calm && ($urandom_range(99) < 29);
  end

  function automatic void wipe_map();
    map_pairs.delete();
    key_list.delete();
  endfunction

  function automatic ihm_pkg::out_t map_apply(ihm_pkg::in_t d);
    ihm_pkg::out_t r;
    bit present;
    r = '0;
    present = map_pairs.exists(d.key);
    case (d.opcode)
      ihm_pkg::OP_INSERT: begin
        if (present) begin
          r.found = 1'b1;
          r.status = ihm_pkg::ST_DUP;
        end else if (map_pairs.num() >= entry_limit) begin
          r.status = ihm_pkg::ST_FULL;
        end else begin
          map_pairs[d.key] = d.value_in;
          key_list.push_back(d.key);
        end
      end
      ihm_pkg::OP_UPDATE: begin
        if (present) begin
          r.found = 1'b1;
          map_pairs[d.key] = d.value_in;
        end else begin
          r.status = ihm_pkg::ST_MISSING;
        end
      end
      ihm_pkg::OP_REMOVE: begin
        if (present) begin
          r.found = 1'b1;
          map_pairs.delete(d.key);
          foreach (key_list[i]) begin
            if (key_list[i] == d.key) begin
              key_list.delete(i);
              break;
            end
          end
        end else begin
          r.status = ihm_pkg::ST_MISSING;
        end
      end
      ihm_pkg::OP_LOOKUP: begin
        if (present) begin
          r.found = 1'b1;
          r.value_out = map_pairs[d.key];
        end else begin
          r.status = ihm_pkg::ST_MISSING;
        end
      end
      ihm_pkg::OP_CLEAR: wipe_map();
      default: ;
    endcase
    r.entry_count = ihm_pkg::CNT_W'(map_pairs.num());
    return r;
  endfunction

  always @(posedge clk) begin
    ihm_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %p", out_data);
        failures++;
      end else begin
        want = pending.pop_front();
        if (out_data.found) hits++;
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          failures++;
        end
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_data.value_out);
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          failures++;
        end
      end
    end
  end

  task automatic send_op(ihm_pkg::in_t d, bit typed, ihm_pkg::out_t res);
    ihm_pkg::out_t guess;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    guess = map_apply(d);
    pending.push_back(typed ? res : guess);
  endtask

  task automatic drain_and_write(bit write_bc, int bc, int me);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    if (write_bc) begin
      cfg_we = 1'b1;
      cfg_index = ihm_pkg::CFG_BUCKET_COUNT;
      cfg_data = ihm_pkg::CFG_DATA_W'(bc);
      wipe_map();
      @(negedge clk);
    end
    cfg_we = 1'b1;
    cfg_index = ihm_pkg::CFG_MAX_ENTRIES;
    cfg_data = ihm_pkg::CFG_DATA_W'(me);
    entry_limit = (me > HW_PAIRS) ? HW_PAIRS : me;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void add_row(logic [2:0] op, logic [ihm_pkg::KEY_W-1:0] key,
                                  logic [ihm_pkg::VAL_W-1:0] val, bit typed,
                                  logic f, logic [ihm_pkg::VAL_W-1:0] v,
                                  ihm_pkg::status_t st);
    row_t r;
    r.op = op;
    r.key = key;
    r.val = val;
    r.typed = typed;
    r.res.found = f;
    r.res.value_out = v;
    r.res.status = st;
    r.res.entry_count = '0;
    rows.push_back(r);
  endfunction

  function automatic void add_phase(bit wbc, int bc, int me, int n, int span, bit c);
    phase_t p;
    p.write_bc = wbc;
    p.bc = bc;
    p.me = me;
    p.items = n;
    p.span = span;
    p.calm = c;
    phases.push_back(p);
  endfunction

  initial begin
    ihm_pkg::in_t d;
    ihm_pkg::out_t res;
    int pick;
    int total_items;

    entry_limit = 0;
    // Default configuration after reset: one bucket and no room for any pair.
    add_row(ihm_pkg::OP_INSERT, 31'd0, 32'd1, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_FULL);
    add_row(ihm_pkg::OP_LOOKUP, 31'h7fffffff, 32'd0, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_MISSING);
    add_row(ihm_pkg::OP_UPDATE, 31'd5, 32'hffffffff, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_MISSING);
    add_row(ihm_pkg::OP_REMOVE, 31'd5, 32'd0, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_MISSING);
    add_row(OP_SPARE5, 31'd3, 32'd7, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(OP_SPARE6, 31'h7fffffff, 32'hffffffff, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(OP_SPARE7, 31'd0, 32'd0, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_CLEAR, 31'd0, 32'd0, 1'b1, 1'b0, 32'd0, ihm_pkg::ST_OK);
    // Zero buckets and an oversized entry limit are clamped by the block.
    add_row(ihm_pkg::OP_INSERT, 31'h7fffffff, 32'h80000000, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_INSERT, 31'd0, 32'h7fffffff, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_INSERT, 31'd0, 32'd9, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_LOOKUP, 31'h7fffffff, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_UPDATE, 31'd0, 32'hffffffff, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_LOOKUP, 31'd0, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_REMOVE, 31'h7fffffff, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_LOOKUP, 31'h7fffffff, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_REMOVE, 31'd0, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_INSERT, 31'd1, 32'd1, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_CLEAR, 31'd0, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);
    add_row(ihm_pkg::OP_LOOKUP, 31'd1, 32'd0, 1'b0, 1'b0, 32'd0, ihm_pkg::ST_OK);

    add_phase(1'b1, 7, 16, 300, 60, 1'b0);
    add_phase(1'b1, 1, 40, 250, 100, 1'b0);
    add_phase(1'b0, 0, 3, 150, 100, 1'b0);
    add_phase(1'b1, 4095, 2047, 400, 5000, 1'b1);
    add_phase(1'b1, 2048, 1024, 300, 1 << 20, 1'b0);
    add_phase(1'b1, 13, 64, 530, 200, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    total_items = 0;
    foreach (rows[i]) begin
      if (i == RESET_ROWS) drain_and_write(1'b1, 0, 2047);
      d.opcode = rows[i].op;
      d.key = rows[i].key;
      d.value_in = rows[i].val;
      res = rows[i].res;
      send_op(d, rows[i].typed, res);
      total_items++;
    end

    foreach (phases[p]) begin
      drain_and_write(phases[p].write_bc, phases[p].bc, phases[p].me);
      calm = phases[p].calm;
      for (int n = 0; n < phases[p].items; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) d.opcode = ihm_pkg::OP_INSERT;
        else if (pick < 50) d.opcode = ihm_pkg::OP_UPDATE;
        else if (pick < 70) d.opcode = ihm_pkg::OP_REMOVE;
        else if (pick < 95) d.opcode = ihm_pkg::OP_LOOKUP;
        else if (pick < 97) d.opcode = ihm_pkg::OP_CLEAR;
        else d.opcode = 3'($urandom_range(OP_SPARE7, OP_SPARE5));
        pick = $urandom_range(99);
        if (pick < 50 && key_list.size() != 0)
          d.key = key_list[$urandom_range(key_list.size() - 1)];
        else if (pick < 88)
          d.key = ihm_pkg::KEY_W'($urandom_range(phases[p].span));
        else
          d.key = ihm_pkg::KEY_W'($urandom);
        d.value_in = $urandom;
        send_op(d, 1'b0, res);
        total_items++;
      end
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Ran %0d operations over %0d table settings; %0d results, %0d found a key.",
             total_items, phases.size() + 2, results_seen, hits);
    if (failures == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
